// File: rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: servo dispense sequencer shared definitions
// Item codes, phase codes, register indexes, reset values, pulse width constants, entry and result types.
// ----------------------------------------------------------------------------
package sds_pkg;

	// item action codes
	typedef enum logic [1:0] {
		ACT_TICK          = 2'd0,
		ACT_WRITE         = 2'd1,
		ACT_START_DEFAULT = 2'd2,
		ACT_START_WEIGHT  = 2'd3
	} action_t;

	// dispense cycle phase codes
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_OPEN = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	// configuration register indexes
	localparam logic [2:0] REG_DEFAULT_PAUSE = 3'd0;
	localparam logic [2:0] REG_CYCLE_PERIOD  = 3'd1;
	localparam logic [2:0] REG_OPEN_ANGLE    = 3'd2;
	localparam logic [2:0] REG_CLOSE_ANGLE   = 3'd3;
	localparam logic [2:0] REG_ENTRY_COUNT   = 3'd4;

	// configuration reset values
	localparam logic [15:0] RST_DEFAULT_PAUSE = 16'd2000;
	localparam logic [15:0] RST_CYCLE_PERIOD  = 16'd0;
	localparam logic [7:0]  RST_OPEN_ANGLE    = 8'd180;
	localparam logic [7:0]  RST_CLOSE_ANGLE   = 8'd0;
	localparam logic [4:0]  RST_ENTRY_COUNT   = 5'd0;

	// pulse width conversion constants
	localparam longint unsigned US_MIN     = 500;
	localparam longint unsigned US_SPAN    = 2000;
	localparam longint unsigned ANGLE_SPAN = 180;
	localparam longint unsigned FRAME_US   = 1000000 / 50;
	localparam longint unsigned DUTY_MAX   = 16383;

	// calibration entry word: weight, angle, pause
	typedef struct packed {
		logic [15:0] weight;
		logic [7:0]  angle;
		logic [15:0] pause;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [13:0] duty;
		phase_t      phase;
		logic        cycle_done;
		logic [3:0]  chosen_index;
		logic        used_default;
		logic        rejected;
	} res_t;

endpackage

// File: rtl/servo_dispense_sequencer.sv
// ----------------------------------------------------------------------------
// servo_dispense_sequencer: servo dispense cycle control
// Tick driven open/hold/close/wait sequencer with a weight calibration table.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_stall, one per action: tick, write entry,
//   start default cycle, start by weight. Every item yields exactly one result
//   item on result_valid/result_stall carrying duty, phase and status flags.
//   Registers are written on cfg_valid/cfg_ready (always ready); write them only
//   while idle, as the block itself does not enforce this.
// Flow:
//   Ticks, entry writes and default starts: the result passes the skid and
//   output registers; a new item is taken only once the skid register is empty.
//   Weighted start: the one comparator walks the table one entry per cycle
//   through the registered ram read (count limited to TABLE_DEPTH); item_stall
//   is high during the walk.
// Reset:
//   arst_n clears the registers to their defaults, the phase to idle and the
//   duty to the angle zero value. Table entries are undefined until written.
// Stall:
//   A result waits in the output register; one further item is taken and its
//   result held in a skid register, after which item_stall stays high.
// ----------------------------------------------------------------------------
module servo_dispense_sequencer import sds_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int DUTY_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  action,
	input  logic [15:0] target_weight,
	input  logic [3:0]  entry_index,
	input  logic [15:0] entry_weight,
	input  logic [7:0]  entry_angle,
	input  logic [15:0] entry_pause,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [13:0] duty,
	output logic [1:0]  phase,
	output logic        cycle_done,
	output logic [3:0]  chosen_index,
	output logic        used_default,
	output logic        rejected,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(entry_t);
	localparam longint unsigned DUTY_RAW0 = (US_MIN << DUTY_BITS) / FRAME_US;
	localparam logic [13:0] DUTY_RESET = 14'((DUTY_RAW0 > DUTY_MAX) ? DUTY_MAX : DUTY_RAW0);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// angle to duty lookup, built at elaboration
	logic [13:0] duty_tbl [256];
	for (genvar g = 0; g < 256; g++) begin : g_duty
		localparam longint unsigned US = longint'(g) * US_SPAN / ANGLE_SPAN + US_MIN;
		localparam longint unsigned RAW = (US << DUTY_BITS) / FRAME_US;
		assign duty_tbl[g] = 14'((RAW > DUTY_MAX) ? DUTY_MAX : RAW);
	end

	// control and state registers
	state_t          state_q;
	logic [15:0]     default_pause_q;
	logic [15:0]     period_q;
	logic [7:0]      open_angle_q;
	logic [7:0]      close_angle_q;
	logic [4:0]      entry_count_q;
	logic [13:0]     duty_q;
	phase_t          phase_q;
	logic [15:0]     wait_q;
	logic [AW-1:0]   last_choice_q;
	logic            default_flag_q;
	logic [15:0]     held_pause_q;
	// search registers
	logic [15:0]     target_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_q;
	logic [AW-1:0]   last_idx_q;
	logic            issue_s1;
	logic [AW-1:0]   idx_s1;
	logic [15:0]     best_diff_q;
	logic [AW-1:0]   best_idx_q;
	logic [7:0]      best_angle_q;
	logic [15:0]     best_pause_q;
	// result skid and output registers
	res_t            res_q;
	logic            res_valid_q;
	res_t            out_q;
	logic            out_valid_q;

	// ram
	logic            ram_we;
	entry_t          ram_wdata;
	entry_t          ram_rdata;
	logic [EW-1:0]   ram_rdata_raw;

	// next state
	logic            item_take;
	logic            in_table;
	logic [CW-1:0]   count_c;
	logic [AW-1:0]   last_idx_c;
	logic [15:0]     wait_dec;
	logic [16:0]     cand_sub;
	logic [15:0]     cand_diff;
	logic            go_search;
	logic            step_en;
	logic            do_open;
	logic            do_close;
	logic [7:0]      open_angle_sel;
	logic [15:0]     open_pause;
	logic [15:0]     close_pause;
	logic [13:0]     nxt_duty;
	phase_t          nxt_phase;
	logic [15:0]     nxt_wait;
	logic [AW-1:0]   nxt_choice;
	logic            nxt_dflt;
	logic [15:0]     nxt_held;
	logic            nxt_done;
	logic            nxt_rej;

	assign item_stall = (state_q != ST_IDLE) || res_valid_q;
	assign item_take  = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// effective table count and write range check
	assign count_c    = (32'(entry_count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
	                                                       : CW'(entry_count_q);
	assign last_idx_c = AW'(count_c - CW'(1));
	assign in_table   = 32'(entry_index) < TABLE_DEPTH;
	assign wait_dec   = (wait_q != 16'd0) ? wait_q - 16'd1 : 16'd0;

	// calibration table
	assign ram_wdata = '{weight: entry_weight, angle: entry_angle, pause: entry_pause};
	assign ram_rdata = entry_t'(ram_rdata_raw);

	sds_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(entry_index)),
		.wdata (ram_wdata),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata_raw)
	);

	// absolute weight difference of the entry being compared
	assign cand_sub  = {1'b0, target_q} - {1'b0, ram_rdata.weight};
	assign cand_diff = cand_sub[16] ? 16'(-cand_sub) : cand_sub[15:0];

	// item decode and cycle step
	always_comb begin
		nxt_duty       = duty_q;
		nxt_phase      = phase_q;
		nxt_wait       = wait_q;
		nxt_choice     = last_choice_q;
		nxt_dflt       = default_flag_q;
		nxt_held       = held_pause_q;
		nxt_done       = 1'b0;
		nxt_rej        = 1'b0;
		go_search      = 1'b0;
		ram_we         = 1'b0;
		do_open        = 1'b0;
		do_close       = 1'b0;
		open_angle_sel = open_angle_q;
		open_pause     = default_pause_q;
		close_pause    = 16'd0;

		priority if (state_q == ST_FINISH) begin
			do_open        = 1'b1;
			open_angle_sel = best_angle_q;
			open_pause     = best_pause_q;
			nxt_choice     = best_idx_q;
			nxt_dflt       = 1'b0;
			nxt_held       = best_pause_q;
		end else if (item_take) begin
			priority if (action == ACT_TICK) begin
				unique case (phase_q)
					PH_OPEN: begin
						nxt_wait = wait_dec;
						if (wait_dec == 16'd0) begin
							do_close    = 1'b1;
							close_pause = default_flag_q ? default_pause_q : held_pause_q;
						end
					end
					PH_WAIT: begin
						nxt_wait = wait_dec;
						if (wait_dec == 16'd0) begin
							nxt_phase = PH_IDLE;
							nxt_done  = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end else if (phase_q != PH_IDLE) begin
				nxt_rej = 1'b1;
			end else if (action == ACT_WRITE) begin
				ram_we = in_table;
			end else if (action == ACT_START_DEFAULT || count_c == '0
			             || target_weight == 16'd0) begin
				do_open  = 1'b1;
				nxt_dflt = 1'b1;
			end else begin
				go_search = 1'b1;
			end
		end else begin
		end

		// drive open, or close at once on a zero pause
		if (do_open) begin
			nxt_duty = duty_tbl[open_angle_sel];
			if (open_pause == 16'd0) begin
				do_close    = 1'b1;
				close_pause = 16'd0;
			end else begin
				nxt_wait  = open_pause;
				nxt_phase = PH_OPEN;
			end
		end

		// drive close, then trailing wait or end of cycle
		if (do_close) begin
			nxt_duty = duty_tbl[close_angle_q];
			if (period_q > close_pause) begin
				nxt_wait  = period_q - close_pause;
				nxt_phase = PH_WAIT;
			end else begin
				nxt_wait  = 16'd0;
				nxt_phase = PH_IDLE;
				nxt_done  = 1'b1;
			end
		end
	end

	assign step_en = (state_q == ST_FINISH) || (item_take && !go_search);

	// sequencer, state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			default_pause_q <= RST_DEFAULT_PAUSE;
			period_q        <= RST_CYCLE_PERIOD;
			open_angle_q    <= RST_OPEN_ANGLE;
			close_angle_q   <= RST_CLOSE_ANGLE;
			entry_count_q   <= RST_ENTRY_COUNT;
			duty_q          <= DUTY_RESET;
			phase_q         <= PH_IDLE;
			wait_q          <= 16'd0;
			last_choice_q   <= '0;
			default_flag_q  <= 1'b0;
			rd_q            <= '0;
			issue_s1        <= 1'b0;
			res_valid_q     <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DEFAULT_PAUSE: default_pause_q <= cfg_data;
					REG_CYCLE_PERIOD:  period_q        <= cfg_data;
					REG_OPEN_ANGLE:    open_angle_q    <= cfg_data[7:0];
					REG_CLOSE_ANGLE:   close_angle_q   <= cfg_data[7:0];
					REG_ENTRY_COUNT:   entry_count_q   <= cfg_data[4:0];
					default: begin
					end
				endcase
			end

			// table walk
			unique case (state_q)
				ST_IDLE: begin
					if (go_search) begin
						state_q    <= ST_SEARCH;
						target_q   <= target_weight;
						count_q    <= count_c;
						last_idx_q <= last_idx_c;
						rd_q       <= '0;
						issue_s1   <= 1'b0;
					end
				end
				ST_SEARCH: begin
					// the read of the last entry is already issued when it is compared
					if (rd_q < count_q) begin
						issue_s1 <= 1'b1;
						idx_s1   <= rd_q[AW-1:0];
						rd_q     <= rd_q + CW'(1);
					end else begin
						issue_s1 <= 1'b0;
					end
					if (issue_s1) begin
						if (idx_s1 == '0 || cand_diff < best_diff_q) begin
							best_diff_q  <= cand_diff;
							best_idx_q   <= idx_s1;
							best_angle_q <= ram_rdata.angle;
							best_pause_q <= ram_rdata.pause;
						end
						if (idx_s1 == last_idx_q) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// cycle state update and result capture
			if (step_en) begin
				duty_q         <= nxt_duty;
				phase_q        <= nxt_phase;
				wait_q         <= nxt_wait;
				last_choice_q  <= nxt_choice;
				default_flag_q <= nxt_dflt;
				held_pause_q   <= nxt_held;
				res_q          <= '{duty: nxt_duty, phase: nxt_phase, cycle_done: nxt_done,
				                    chosen_index: 4'(nxt_choice), used_default: nxt_dflt,
				                    rejected: nxt_rej};
				res_valid_q    <= 1'b1;
			end

			// output register fed from the skid register
			if (res_valid_q && (!out_valid_q || !result_stall)) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
				res_valid_q <= 1'b0;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign duty         = out_q.duty;
	assign phase        = out_q.phase;
	assign cycle_done   = out_q.cycle_done;
	assign chosen_index = out_q.chosen_index;
	assign used_default = out_q.used_default;
	assign rejected     = out_q.rejected;

	// an active phase always has ticks left to count
	a_phase_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) == (wait_q == 16'd0))
		else $error("phase and wait counter disagree");

	// no result is produced while the table walk runs
	a_search_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !res_valid_q)
		else $error("result produced during table walk");

	// the chosen entry lies within the searched range
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (best_idx_q <= last_idx_q))
		else $error("chosen entry beyond searched count");

	// a rejected item leaves a cycle running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.rejected) |-> (out_q.phase != PH_IDLE))
		else $error("rejection reported while idle");

endmodule

// File: rtl/sds_ram.sv
// ----------------------------------------------------------------------------
// sds_ram: generic simple dual port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sds_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
